// ===== rtl/core/rctp_pkg.sv =====
package rctp_pkg;

  localparam int REP_W = 31;
  localparam logic [REP_W-1:0] REP_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] K_RUN = 2'd0;
  localparam logic [1:0] K_END = 2'd1;
  localparam logic [1:0] K_ERR = 2'd2;

  localparam logic [1:0] PH_BETWEEN = 2'd0;
  localparam logic [1:0] PH_TOKEN   = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;
  localparam logic [1:0] PH_STOP    = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] value;
    logic [REP_W-1:0]  repeat_count;
  } out_item_t;

endpackage

// ===== rtl/core/rctp_in_if.sv =====
interface rctp_in_if import rctp_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rctp_out_if.sv =====
interface rctp_out_if import rctp_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/repeat_count_integer_token_parser_unit.sv =====
// Channel   Dir  Payload                               Handshake
// in_if     in   char_byte[7:0], end_of_input          valid/ready
// out_if    out  kind[1:0], value[31:0], repeat_count  valid/ready
//
// One byte item per cycle while in_if.ready is high. An accepted item is
// registered, parsed in the next cycle and its 0..2 results are written to
// an 8-entry output queue.
// in_if.ready drops while the queue plus the results of the registered item
// and of a new item could exceed the queue depth; out_if stalls only back up
// into the queue.
// Synchronous active-low reset clears the parser to between-tokens.
module repeat_count_integer_token_parser_unit
  import rctp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  rctp_in_if.sink      in_if,
  rctp_out_if.source   out_if
);

  localparam int MAG_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = 3;
  localparam int CNT_W = 4;
  localparam logic [MAG_W-1:0] VAL_LIM = MAG_W'(1) << (VALUE_BITS - 1);
  localparam logic [MAG_W-1:0] REP_MAX_M = MAG_W'(REP_MAX);

  typedef struct packed {
    logic             has_chars;
    logic             minus_held;
    logic             neg;
    logic             has_digit;
    logic             sign_taken;
    logic             invalid;
    logic             star_seen;
    logic             ovf;
    logic [MAG_W-1:0] mag;
    logic [REP_W-1:0] rep;
  } tok_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic tok_t seg_clear(tok_t s);
    tok_t r;
    r = s;
    r.neg = 1'b0;
    r.mag = '0;
    r.has_digit = 1'b0;
    r.sign_taken = 1'b0;
    r.ovf = 1'b0;
    return r;
  endfunction

  function automatic tok_t tok_clear();
    tok_t r;
    r = '0;
    r.rep = REP_W'(1);
    return r;
  endfunction

  function automatic tok_t put_char(tok_t s, logic [7:0] c);
    tok_t r;
    logic [MAG_W+3:0] wide;
    logic rep_bad;
    r = s;
    wide = ({4'b0, s.mag} << 3) + ({4'b0, s.mag} << 1) + {MAG_W'(0), c[3:0]};
    rep_bad = !s.has_digit || s.neg || s.ovf || (s.mag == '0) || (s.mag > REP_MAX_M);
    if ((c >= CH_0) && (c <= CH_9)) begin
      r.has_digit = 1'b1;
      r.ovf = s.ovf || (wide[MAG_W+3:MAG_W] != 4'd0);
      r.mag = wide[MAG_W-1:0];
    end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      if (!s.has_digit && !s.sign_taken) begin
        r.sign_taken = 1'b1;
        r.neg = (c == CH_MINUS);
      end else begin
        r.invalid = 1'b1;
      end
    end else if ((c == CH_STAR) && !s.star_seen && s.has_chars) begin
      if (rep_bad) begin
        r.invalid = 1'b1;
      end else begin
        r.rep = s.mag[REP_W-1:0];
      end
      r.star_seen = 1'b1;
      r = seg_clear(r);
    end else begin
      r.invalid = 1'b1;
    end
    r.has_chars = 1'b1;
    return r;
  endfunction

  function automatic tok_t release_minus(tok_t s);
    tok_t r;
    r = s;
    if (s.minus_held) begin
      r.minus_held = 1'b0;
      r = put_char(r, CH_MINUS);
    end
    return r;
  endfunction

  function automatic logic tok_ok(tok_t s);
    return !s.invalid && s.has_digit && !s.ovf &&
           (s.neg ? (s.mag <= VAL_LIM) : (s.mag < VAL_LIM));
  endfunction

  function automatic out_item_t run_item(tok_t s);
    out_item_t o;
    logic [MAG_W-1:0] v;
    v = s.neg ? (MAG_W'(0) - s.mag) : s.mag;
    o.kind = K_RUN;
    o.value = v[31:0];
    o.repeat_count = s.star_seen ? s.rep : REP_W'(1);
    return o;
  endfunction

  function automatic out_item_t code_item(logic [1:0] k);
    out_item_t o;
    o = '0;
    o.kind = k;
    return o;
  endfunction

  logic             s1_v_r;
  in_item_t         s1_item_r;
  logic [1:0]       phase_r, phase_nxt;
  tok_t             tok_r, tok_nxt;
  logic [1:0]       n_push;
  out_item_t        res0, res1;

  out_item_t        fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;
  logic [CNT_W:0]   room_need;

  assign room_need = {1'b0, cnt_r} + (s1_v_r ? (CNT_W+1)'(2) : (CNT_W+1)'(0));
  assign in_if.ready = room_need <= (CNT_W+1)'(FIFO_DEPTH - 2);
  assign out_if.valid = cnt_r != '0;
  assign out_if.data = fifo_r[rd_ptr_r];
  assign pop = out_if.valid && out_if.ready;

  always_comb begin
    tok_t t;
    tok_t tr;
    logic [7:0] c;
    t = tok_r;
    tr = tok_r;
    c = s1_item_r.char_byte;
    phase_nxt = phase_r;
    tok_nxt = tok_r;
    n_push = 2'd0;
    res0 = code_item(K_ERR);
    res1 = code_item(K_ERR);
    if (s1_v_r && (phase_r != PH_STOP)) begin
      if (s1_item_r.end_of_input) begin
        phase_nxt = PH_STOP;
        n_push = 2'd1;
        if (phase_r == PH_TOKEN) begin
          tr = release_minus(tok_r);
          if (tr.has_chars && tok_ok(tr)) begin
            res0 = run_item(tr);
            n_push = 2'd2;
          end
        end
      end else if (phase_r == PH_SKIP) begin
        if (c == CH_LF) begin
          phase_nxt = PH_BETWEEN;
        end
      end else if ((phase_r == PH_BETWEEN) && is_space(c)) begin
        phase_nxt = PH_BETWEEN;
      end else if ((phase_r == PH_BETWEEN) && (c == CH_SLASH)) begin
        res0 = code_item(K_END);
        n_push = 2'd1;
        phase_nxt = PH_STOP;
      end else begin
        t = (phase_r == PH_BETWEEN) ? tok_clear() : tok_r;
        if ((c == CH_MINUS) && t.minus_held) begin
          if (t.has_chars && !tok_ok(t)) begin
            n_push = 2'd1;
            phase_nxt = PH_STOP;
          end else begin
            if (t.has_chars) begin
              res0 = run_item(t);
              n_push = 2'd1;
            end
            tok_nxt = tok_clear();
            phase_nxt = PH_SKIP;
          end
        end else if (is_space(c) || (c == CH_SLASH)) begin
          tr = release_minus(t);
          if (tr.has_chars && !tok_ok(tr)) begin
            n_push = 2'd1;
            phase_nxt = PH_STOP;
          end else begin
            tok_nxt = tok_clear();
            if (c == CH_SLASH) begin
              phase_nxt = PH_STOP;
              if (tr.has_chars) begin
                res0 = run_item(tr);
                res1 = code_item(K_END);
                n_push = 2'd2;
              end else begin
                res0 = code_item(K_END);
                n_push = 2'd1;
              end
            end else begin
              phase_nxt = PH_BETWEEN;
              if (tr.has_chars) begin
                res0 = run_item(tr);
                n_push = 2'd1;
              end
            end
          end
        end else begin
          tr = release_minus(t);
          if (c == CH_MINUS) begin
            tr.minus_held = 1'b1;
          end else begin
            tr = put_char(tr, c);
          end
          tok_nxt = tr;
          phase_nxt = PH_TOKEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      phase_r <= PH_BETWEEN;
      tok_r <= tok_clear();
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      s1_v_r <= in_if.valid && in_if.ready;
      phase_r <= phase_nxt;
      tok_r <= tok_nxt;
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r <= cnt_r + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= in_if.data;
    end
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |=> phase_r == PH_STOP)
    else $error("parser left stopped phase");

  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |-> n_push == 2'd0)
    else $error("result produced while stopped");

  a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
    n_push == 2'd2 |-> (res0.kind == K_RUN) && (res1.kind != K_RUN) &&
                       (phase_nxt == PH_STOP))
    else $error("two results without stopping");

endmodule

// ===== tb/rctp_checker.sv =====
`timescale 1ns / 100ps
module rctp_checker
  import rctp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rctp_in_if   in_mon,
  rctp_out_if  out_mon,
  output int   fail_count,
  output int   waiting,
  output int   in_count,
  output int   run_count,
  output int   end_count,
  output int   err_count
);

  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MAG_SAT   = '1;

  logic [1:0]       ph;
  bit               tok_chars;
  bit               minus_pend;
  bit               seg_neg;
  bit               seg_digit;
  bit               seg_signed;
  bit               tok_bad;
  bit               star_split;
  logic [63:0]      seg_mag;
  logic [REP_W-1:0] run_len;
  out_item_t        parsed_items[$];

  function automatic void push_result(logic [1:0] k, logic [31:0] v, logic [REP_W-1:0] r);
    out_item_t e;
    e.kind = k;
    e.value = v;
    e.repeat_count = r;
    parsed_items = {parsed_items, e};
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_segment();
    seg_neg = 1'b0;
    seg_mag = '0;
    seg_digit = 1'b0;
    seg_signed = 1'b0;
  endfunction

  function automatic void clear_token();
    clear_segment();
    tok_chars = 1'b0;
    minus_pend = 1'b0;
    tok_bad = 1'b0;
    star_split = 1'b0;
    run_len = REP_W'(1);
  endfunction

  function automatic void feed_char(logic [7:0] c);
    logic [63:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = {56'd0, c - CH_0};
      seg_digit = 1'b1;
      if (seg_mag > (MAG_SAT - d) / 10) seg_mag = MAG_SAT;
      else seg_mag = seg_mag * 10 + d;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (!seg_digit && !seg_signed) begin
        seg_signed = 1'b1;
        seg_neg = (c == CH_MINUS);
      end else begin
        tok_bad = 1'b1;
      end
    end else if (c == CH_STAR) begin
      if (!star_split && tok_chars) begin
        if (!seg_digit || seg_neg || seg_mag < 1 || seg_mag > {33'd0, REP_MAX}) tok_bad = 1'b1;
        else run_len = seg_mag[REP_W-1:0];
        star_split = 1'b1;
        clear_segment();
      end else begin
        tok_bad = 1'b1;
      end
    end else begin
      tok_bad = 1'b1;
    end
    tok_chars = 1'b1;
  endfunction

  function automatic void flush_minus();
    if (minus_pend) begin
      minus_pend = 1'b0;
      feed_char(CH_MINUS);
    end
  endfunction

  // 0 when the token was malformed; the error is already queued then
  function automatic bit close_token();
    logic [63:0] v;
    bit ok;
    if (!tok_chars) return 1'b1;
    ok = !tok_bad && seg_digit && (seg_neg ? seg_mag <= NEG_LIMIT : seg_mag <= POS_LIMIT);
    if (!ok) begin
      push_result(K_ERR, '0, '0);
      return 1'b0;
    end
    v = seg_neg ? -seg_mag : seg_mag;
    push_result(K_RUN, v[31:0], star_split ? run_len : REP_W'(1));
    clear_token();
    return 1'b1;
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic eoi);
    if (ph == PH_STOP) return;
    if (eoi) begin
      if (ph == PH_TOKEN) begin
        flush_minus();
        if (!close_token()) begin
          ph = PH_STOP;
          return;
        end
      end
      push_result(K_ERR, '0, '0);
      ph = PH_STOP;
      return;
    end
    if (ph == PH_SKIP) begin
      if (c == CH_LF) ph = PH_BETWEEN;
      return;
    end
    if (ph == PH_BETWEEN) begin
      if (is_ws(c)) return;
      if (c == CH_SLASH) begin
        push_result(K_END, '0, '0);
        ph = PH_STOP;
        return;
      end
      clear_token();
      ph = PH_TOKEN;
    end
    if (c == CH_MINUS && minus_pend) begin
      minus_pend = 1'b0;
      ph = PH_SKIP;
      if (!close_token()) ph = PH_STOP;
      clear_token();
      return;
    end
    if (is_ws(c) || c == CH_SLASH) begin
      flush_minus();
      if (!close_token()) begin
        ph = PH_STOP;
        return;
      end
      clear_token();
      if (c == CH_SLASH) begin
        push_result(K_END, '0, '0);
        ph = PH_STOP;
      end else begin
        ph = PH_BETWEEN;
      end
      return;
    end
    flush_minus();
    if (c == CH_MINUS) minus_pend = 1'b1;
    else feed_char(c);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (parsed_items.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result kind %0d value %0d count %0d", $time,
               got.kind, got.value, got.repeat_count);
      return;
    end
    want = parsed_items.pop_front();
    case (want.kind)
      K_RUN:   run_count++;
      K_END:   end_count++;
      default: err_count++;
    endcase
    if (got.kind !== want.kind || got.value !== want.value ||
        got.repeat_count !== want.repeat_count) begin
      fail_count++;
      $display("%0t: expected kind %0d value %0d count %0d, got kind %0d value %0d count %0d",
               $time, want.kind, want.value, want.repeat_count,
               got.kind, got.value, got.repeat_count);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ph = PH_BETWEEN;
      clear_token();
      parsed_items.delete();
      fail_count = 0;
      in_count = 0;
      run_count = 0;
      end_count = 0;
      err_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result(out_mon.data);
      if (in_mon.valid && in_mon.ready) begin
        in_count++;
        parse_byte(in_mon.data.char_byte, in_mon.data.end_of_input);
      end
    end
    waiting = parsed_items.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import rctp_pkg::*;

  typedef enum int {
    STOP_SLASH_BETWEEN,
    STOP_SLASH_IN_TOKEN,
    STOP_EOF_BETWEEN,
    STOP_EOF_IN_TOKEN,
    STOP_EOF_MINUS,
    STOP_EOF_COMMENT,
    STOP_BAD_BYTE,
    STOP_VALUE_RANGE,
    STOP_REPEAT_RANGE,
    STOP_STAR_FIRST,
    STOP_STAR_TWICE,
    STOP_EMPTY_PART,
    STOP_LATE_SIGN,
    STOP_NEG_REPEAT,
    STOP_BAD_BEFORE_SLASH,
    STOP_KINDS
  } stop_kind_t;

  localparam int          TEXT_BYTES = 1600;
  localparam logic [7:0]  CH_VT = 8'h0B;
  localparam logic [7:0]  CH_FF = 8'h0C;
  localparam longint      VAL_MIN = -64'sd2147483648;
  localparam longint      VAL_MAX = 64'sd2147483647;

  logic       clk;
  logic       rst_n;
  rctp_in_if  in_ch();
  rctp_out_if out_ch();

  int         fail_count;
  int         waiting;
  int         in_count;
  int         run_count;
  int         end_count;
  int         err_count;
  int         rx_stall_pct = 0;
  int         parsed_len;
  stop_kind_t stop_kind;
  in_item_t   text[$];
  logic [7:0] ws_chars[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  repeat_count_integer_token_parser_unit dut (
    .clk,
    .rst_n,
    .in_if(in_ch),
    .out_if(out_ch)
  );

  rctp_checker chk (
    .clk,
    .rst_n,
    .in_mon(in_ch),
    .out_mon(out_ch),
    .fail_count,
    .waiting,
    .in_count,
    .run_count,
    .end_count,
    .err_count
  );

  function automatic void put(logic [7:0] c);
    in_item_t it;
    it.char_byte = c;
    it.end_of_input = 1'b0;
    text = {text, it};
  endfunction

  function automatic void put_eoi();
    in_item_t it;
    it.char_byte = 8'($urandom);
    it.end_of_input = 1'b1;
    text = {text, it};
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_digits(longint unsigned mag);
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 30)) put(CH_0);
    put_str($sformatf("%0d", mag));
  endfunction

  function automatic longint rand_val();
    longint x;
    case ($urandom_range(7))
      4, 5: return longint'(int'($urandom));
      6: begin
        case ($urandom_range(4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return -64'sd1;
          3: return 64'sd1;
          default: return 64'sd0;
        endcase
      end
      7: return longint'($urandom_range(99999999));
      default: begin
        x = longint'($urandom_range(999));
        return $urandom_range(1) ? -x : x;
      end
    endcase
  endfunction

  function automatic void put_value(longint v);
    if (v < 0 || (v == 0 && $urandom_range(3) == 0)) begin
      put(CH_MINUS);
      put_digits(-v);
    end else begin
      if ($urandom_range(2) == 0) put(CH_PLUS);
      put_digits(v);
    end
  endfunction

  function automatic void put_count();
    longint unsigned r;
    case ($urandom_range(7))
      6: r = longint'($urandom_range(1, 32'h7FFF_FFFF));
      7: r = $urandom_range(1) ? longint'(REP_MAX) : 64'd1;
      default: r = longint'($urandom_range(1, 20));
    endcase
    if ($urandom_range(3) == 0) put(CH_PLUS);
    put_digits(r);
    put(CH_STAR);
  endfunction

  function automatic void put_token();
    if ($urandom_range(2) == 0) put_count();
    put_value(rand_val());
  endfunction

  function automatic void put_comment();
    logic [7:0] c;
    put(CH_MINUS);
    put(CH_MINUS);
    repeat ($urandom_range(12)) begin
      c = 8'($urandom);
      if (c == CH_LF) c = 8'hFF;
      put(c);
    end
    put(CH_LF);
  endfunction

  function automatic void put_break();
    if ($urandom_range(6) == 0) put_comment();
    else repeat ($urandom_range(1, 3)) put(ws_chars[3'($urandom_range(5))]);
  endfunction

  function automatic void put_stop(stop_kind_t k);
    logic [7:0] c;
    case (k)
      STOP_SLASH_BETWEEN: put(CH_SLASH);
      STOP_SLASH_IN_TOKEN: begin
        put_token();
        put(CH_SLASH);
      end
      STOP_EOF_BETWEEN: put_eoi();
      STOP_EOF_IN_TOKEN: begin
        put_token();
        put_eoi();
      end
      STOP_EOF_MINUS: begin
        put_token();
        put(CH_MINUS);
        put_eoi();
      end
      STOP_EOF_COMMENT: begin
        put_str("--tail");
        put_eoi();
      end
      STOP_BAD_BYTE: begin
        do c = 8'($urandom);
        while ((c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
               c == CH_SLASH || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
        put_token();
        put(c);
        put(CH_SPACE);
      end
      STOP_VALUE_RANGE: begin
        case ($urandom_range(2))
          0: put_str("2147483648 ");
          1: put_str("-2147483649 ");
          default: put_str("5*99999999999999999999999 ");
        endcase
      end
      STOP_REPEAT_RANGE: begin
        case ($urandom_range(2))
          0: put_str("0*5 ");
          1: put_str("2147483648*1 ");
          default: put_str("+00*3 ");
        endcase
      end
      STOP_STAR_FIRST: put_str("*5 ");
      STOP_STAR_TWICE: put_str("2*3*4 ");
      STOP_EMPTY_PART: begin
        case ($urandom_range(3))
          0: put_str("3* ");
          1: put_str("+ ");
          2: put_str("7*- ");
          default: put_str("3*--\n");
        endcase
      end
      STOP_LATE_SIGN: begin
        case ($urandom_range(2))
          0: put_str("5+3 ");
          1: put_str("+-5 ");
          default: put_str("12- ");
        endcase
      end
      STOP_NEG_REPEAT: put_str("-3*5 ");
      default: begin
        if ($urandom_range(1)) put_str("3*/");
        else put_str("5-/");
      end
    endcase
  endfunction

  function automatic void build_text();
    text.delete();
    // widest repeat and values, every whitespace byte, comments with any byte
    put_str("2147483647*-2147483648 +1*+2147483647\t-0 007*+0");
    put(CH_VT);
    put_str("-5--");
    put(8'h00);
    put(8'hFF);
    put(CH_LF);
    put_str("--\n3*2");
    put(CH_FF);
    put(CH_CR);
    while (text.size() < TEXT_BYTES) begin
      if ($urandom_range(11) == 0) begin
        put_comment();
      end else begin
        put_token();
        put_break();
      end
    end
    stop_kind = stop_kind_t'($urandom_range(0, STOP_KINDS - 1));
    put_stop(stop_kind);
    parsed_len = text.size();
    // the parser is halted now; these must be dropped
    put_eoi();
    repeat ($urandom_range(30, 60)) begin
      if ($urandom_range(3) == 0) put_eoi();
      else put(8'($urandom));
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("repeat_count_integer_token_parser_unit: mismatch");
    $finish;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);

  initial begin
    int tx_idle_pct;
    int mode;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    rst_n <= 1'b0;
    build_text();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < text.size(); i++) begin
      mode = (i * 4) / text.size();
      case (mode)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 54;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 54;
        end
        default: begin
          tx_idle_pct = 27;
          rx_stall_pct <= 27;
        end
      endcase
      if (i == parsed_len / 2) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (waiting != 0);
        @(posedge clk);
      end else begin
        while ($urandom_range(99) < tx_idle_pct) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
        end
      end
      in_ch.valid <= 1'b1;
      in_ch.data <= text[i];
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("Fed %0d bytes, %0d before the parser halted on %s.", in_count, parsed_len,
             stop_kind.name());
    $display("Compared %0d value runs, %0d end markers and %0d parse errors.", run_count,
             end_count, err_count);
    if (fail_count == 0 && waiting == 0) begin
      $display("repeat_count_integer_token_parser_unit: match");
    end else begin
      $display("repeat_count_integer_token_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
